>>> rtl/m3inv_pkg.sv
// Package: widths and parameter defaults for the 3x3 inverse.
`timescale 1ns / 1ps
package m3inv_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ELEMS = 9;
  localparam int NUM_LANES = 9;
endpackage

>>> rtl/m3inv_divlane.sv
// One division lane: a restoring divider pipeline, one quotient bit per stage, then saturation.
`timescale 1ns / 1ps
module m3inv_divlane import m3inv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ADJ_BITS  = 2 * WORD_BITS + 1,
  parameter int DET_BITS  = 3 * WORD_BITS + 2
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [ADJ_BITS-1:0]  adj,
  input  logic signed [DET_BITS-1:0]  det,
  output logic signed [WORD_BITS-1:0] quo
);
  // numerator magnitude shifted by 2F; quotient needs only WORD_BITS+1 bits before saturation
  localparam int NUM_BITS = ADJ_BITS + 2 * FRAC_BITS;
  localparam int QB       = WORD_BITS + 1;
  localparam int STAGES   = NUM_BITS;
  localparam int RB       = DET_BITS + 1;

  logic [NUM_BITS-1:0] num  [0:STAGES];
  logic [RB-1:0]       rem  [0:STAGES];
  logic [DET_BITS-1:0] den  [0:STAGES];
  logic                big  [0:STAGES];
  logic [QB-1:0]       qacc [0:STAGES];
  logic                neg  [0:STAGES];

  logic [ADJ_BITS-1:0] adj_mag;
  logic [DET_BITS-1:0] det_mag;

  assign adj_mag = adj[ADJ_BITS-1] ? ADJ_BITS'(-adj) : ADJ_BITS'(adj);
  assign det_mag = det[DET_BITS-1] ? DET_BITS'(-det) : DET_BITS'(det);

  always_comb begin
    num[0]  = {adj_mag, {(2 * FRAC_BITS){1'b0}}};
    rem[0]  = '0;
    den[0]  = det_mag;
    big[0]  = 1'b0;
    qacc[0] = '0;
    neg[0]  = adj[ADJ_BITS-1] ^ det[DET_BITS-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RB-1:0] shifted;
    logic [RB:0]   diff;
    logic          qbit;
    assign shifted = {rem[s][RB-2:0], num[s][NUM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b0, den[s]};
    assign qbit    = !diff[RB];
    always_ff @(posedge clk) begin
      if (en) begin
        num[s+1]  <= {num[s][NUM_BITS-2:0], 1'b0};
        rem[s+1]  <= qbit ? diff[RB-1:0] : shifted;
        den[s+1]  <= den[s];
        neg[s+1]  <= neg[s];
        big[s+1]  <= big[s] | (qacc[s][QB-1] & 1'b1);
        qacc[s+1] <= {qacc[s][QB-2:0], qbit};
      end
    end
  end

  logic [QB-1:0] mag;
  logic [QB-1:0] lim;
  logic [QB-1:0] sat;
  assign mag = qacc[STAGES];
  assign lim = neg[STAGES] ? (QB'(1) << (WORD_BITS - 1)) : ((QB'(1) << (WORD_BITS - 1)) - QB'(1));
  assign sat = (big[STAGES] || mag > lim) ? lim : mag;
  always_ff @(posedge clk) begin
    if (en) quo <= neg[STAGES] ? WORD_BITS'(-sat) : WORD_BITS'(sat);
  end
endmodule

>>> rtl/m3inv_front.sv
// Front end: cofactors, then determinant, each product registered.
`timescale 1ns / 1ps
module m3inv_front import m3inv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int ADJ_BITS  = 2 * WORD_BITS + 1,
  parameter int DET_BITS  = 3 * WORD_BITS + 2
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [WORD_BITS-1:0] a   [NUM_ELEMS],
  output logic signed [ADJ_BITS-1:0]  adj [NUM_ELEMS],
  output logic signed [DET_BITS-1:0]  det
);
  localparam int PB = 2 * WORD_BITS;
  // determinant terms: element times cofactor, split into upper and lower cofactor slices
  localparam int HB = ADJ_BITS - WORD_BITS;
  localparam int XB = WORD_BITS + HB;
  // cofactor operand indices p,q,r,s: adj = a[p]*a[q] - a[r]*a[s]
  localparam int IP [NUM_ELEMS] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IQ [NUM_ELEMS] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IR [NUM_ELEMS] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IS [NUM_ELEMS] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // cofactor paired with each row-0 element in the determinant
  localparam int IC [3] = '{0, 3, 6};

  logic signed [PB-1:0]        p1 [NUM_ELEMS];
  logic signed [PB-1:0]        p2 [NUM_ELEMS];
  logic signed [WORD_BITS-1:0] a_d1 [3];
  logic signed [WORD_BITS-1:0] a_d2 [3];
  logic signed [ADJ_BITS-1:0]  adj1 [NUM_ELEMS];
  logic signed [ADJ_BITS-1:0]  adj2 [NUM_ELEMS];
  logic signed [XB-1:0]        th [3];
  logic signed [XB-1:0]        tl [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        p1[i]   <= a[IP[i]] * a[IQ[i]];
        p2[i]   <= a[IR[i]] * a[IS[i]];
        adj1[i] <= ADJ_BITS'(p1[i]) - ADJ_BITS'(p2[i]);
        adj2[i] <= adj1[i];
        adj[i]  <= adj2[i];
      end
      for (int k = 0; k < 3; k++) begin
        a_d1[k] <= a[k];
        a_d2[k] <= a_d1[k];
        th[k]   <= a_d2[k] * signed'(adj1[IC[k]][ADJ_BITS-1:WORD_BITS]);
        tl[k]   <= a_d2[k] * signed'({1'b0, adj1[IC[k]][WORD_BITS-1:0]});
      end
      det <= ((DET_BITS'(th[0]) + DET_BITS'(th[1]) + DET_BITS'(th[2])) <<< WORD_BITS)
             + DET_BITS'(tl[0]) + DET_BITS'(tl[1]) + DET_BITS'(tl[2]);
    end
  end
endmodule

>>> rtl/matrix3_inverse_top.sv
// Top level: 3x3 fixed-point matrix inverse by adjugate, nine divider lanes.
`timescale 1ns / 1ps
// Usage
//   Input channel: nine signed elements a00..a22 with in_valid / in_stall.
//   Output channel: nine signed elements b00..b22 plus singular, out_valid / out_stall.
//   One item in, one item out, in order.
// Throughput: one item per cycle unless stalled; the whole datapath is one pipeline.
// Pipeline: 3 front stages (products, cofactors, determinant products),
//   1 determinant sum, then one stage per numerator bit in each of the nine
//   divider lanes (2W+1+2F stages), one saturation stage and the merge register.
// Stall: the pipeline advances as a whole; out_stall with a result
//   waiting freezes every stage, and in_stall follows out_stall, so the
//   next item is still taken whenever the output register is free or leaving.
// Reset: clears the stage valid bits; payload registers are not reset.
// Singular: a zero determinant gives all-zero elements with singular set.
module matrix3_inverse_top import m3inv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [WORD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [WORD_BITS-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
  output logic singular
);
  localparam int ADJ_BITS = 2 * WORD_BITS + 1;
  localparam int DET_BITS = 3 * WORD_BITS + 2;
  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT = ADJ_BITS + 2 * FRAC_BITS + 1;
  localparam int LAT = FRONT_LAT + DIV_LAT;

  logic en;
  logic [LAT-1:0] vpipe;
  // zero flag joins at the determinant register, so it only spans the lanes
  logic [DIV_LAT-1:0] zpipe;

  // stall everything only when a result sits in the output and is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [WORD_BITS-1:0] a   [NUM_ELEMS];
  logic signed [ADJ_BITS-1:0]  adj [NUM_ELEMS];
  logic signed [DET_BITS-1:0]  det;
  logic signed [WORD_BITS-1:0] q   [NUM_LANES];
  logic signed [WORD_BITS-1:0] b   [NUM_ELEMS];

  assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  m3inv_front #(.WORD_BITS(WORD_BITS), .ADJ_BITS(ADJ_BITS), .DET_BITS(DET_BITS)) u_front (
    .clk(clk), .en(en), .a(a), .adj(adj), .det(det)
  );

  // a zero divisor is harmless in the lanes; the merge forces the result
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    m3inv_divlane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS),
                    .ADJ_BITS(ADJ_BITS), .DET_BITS(DET_BITS)) u_lane (
      .clk(clk), .en(en), .adj(adj[l]), .det(det), .quo(q[l])
    );
  end

  // valid and zero-determinant flag travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) zpipe <= {zpipe[DIV_LAT-2:0], (det == '0)};
  end

  // merge stage: singular result overrides all lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      singular <= zpipe[DIV_LAT-1];
      for (int i = 0; i < NUM_ELEMS; i++) b[i] <= zpipe[DIV_LAT-1] ? '0 : q[i];
    end
  end

  assign b00 = b[0];
  assign b01 = b[1];
  assign b02 = b[2];
  assign b10 = b[3];
  assign b11 = b[4];
  assign b12 = b[5];
  assign b20 = b[6];
  assign b21 = b[7];
  assign b22 = b[8];

  // a held result keeps its flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(singular))
    else $error("held result changed");
  // a singular result carries zero elements; b00, b11, b22 and b01 are checked
  assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> b00 == '0 && b11 == '0 && b22 == '0 && b01 == '0)
    else $error("singular result not zero");
  // input is blocked only while the output is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("spurious input stall");
endmodule

>>> test/matrix3_inverse_chk.sv
// Checker: predicts each inverse from the accepted matrix and compares the results.
`timescale 1ns / 1ps
module matrix3_inverse_chk (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
  input  logic singular,
  output int errors,
  output int pending
);
  typedef struct packed {
    logic [8:0][31:0] elem;
    logic             sing;
  } inverse_t;

  inverse_t inv_q[$];
  string    names[10] = '{"b00", "b01", "b02", "b10", "b11", "b12", "b20", "b21", "b22",
                          "singular"};

  initial begin
    errors = 0;
    pending = 0;
  end

  // adjugate over determinant, exact in 128 bits, truncated and saturated
  function automatic inverse_t invert3(input logic [8:0][31:0] m);
    logic signed [127:0] w[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic signed [127:0] q;
    inverse_t            res;
    for (int i = 0; i < 9; i++) w[i] = 128'(signed'(m[i]));
    adj[0] = w[4] * w[8] - w[5] * w[7];
    adj[1] = w[2] * w[7] - w[1] * w[8];
    adj[2] = w[1] * w[5] - w[2] * w[4];
    adj[3] = w[5] * w[6] - w[3] * w[8];
    adj[4] = w[0] * w[8] - w[2] * w[6];
    adj[5] = w[2] * w[3] - w[0] * w[5];
    adj[6] = w[3] * w[7] - w[4] * w[6];
    adj[7] = w[1] * w[6] - w[0] * w[7];
    adj[8] = w[0] * w[4] - w[1] * w[3];
    det = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) begin
        q = (adj[i] <<< 32) / det;
        if (q > 128'sh7FFF_FFFF) res.elem[i] = 32'h7FFF_FFFF;
        else if (q < -128'sh8000_0000) res.elem[i] = 32'h8000_0000;
        else res.elem[i] = q[31:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    inverse_t want;
    inverse_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        inv_q.push_back(invert3({a22, a21, a20, a12, a11, a10, a02, a01, a00}));
      if (out_valid && !out_stall) begin
        got.elem = {b22, b21, b20, b12, b11, b10, b02, b01, b00};
        got.sing = singular;
        if (inv_q.size() == 0) begin
          $error("result with no matrix outstanding");
          errors++;
        end else begin
          want = inv_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.elem[i] !== want.elem[i]) begin
              $error("%s: expected %h, got %h", names[i], want.elem[i], got.elem[i]);
              errors++;
            end
          if (got.sing !== want.sing) begin
            $error("%s: expected %b, got %b", names[9], want.sing, got.sing);
            errors++;
          end
        end
      end
    end
    pending = inv_q.size();
  end
endmodule

>>> test/tb_top.sv
// Testbench top: matrix stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_top;
  localparam int ONE      = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int LATENCY  = 103;
  localparam int HOLD_LEN = 500;            // long receiver hold-off
  localparam int IDLE_MAX = 4000;           // watchdog: cycles with no handshake
  localparam int N_RANDOM = 1130;

  typedef enum int {MK_FULL, MK_SMALL, MK_DIAG, MK_SINGULAR, MK_TINY} mat_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, singular;
  logic signed [31:0] a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
  logic signed [31:0] a20 = '0, a21 = '0, a22 = '0;
  logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  int errors, pending;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  matrix3_inverse_top uut (
    .clk, .rst, .in_valid, .in_stall,
    .a00, .a01, .a02, .a10, .a11, .a12, .a20, .a21, .a22,
    .out_valid, .out_stall,
    .b00, .b01, .b02, .b10, .b11, .b12, .b20, .b21, .b22, .singular
  );

  matrix3_inverse_chk chk (
    .clk, .rst, .in_valid, .in_stall,
    .a00, .a01, .a02, .a10, .a11, .a12, .a20, .a21, .a22,
    .out_valid, .out_stall,
    .b00, .b01, .b02, .b10, .b11, .b12, .b20, .b21, .b22, .singular,
    .errors, .pending
  );

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [8:0][31:0] make_matrix(input mat_kind_t kind);
    logic [8:0][31:0] m;
    int scale;
    for (int i = 0; i < 9; i++) m[i] = $urandom;
    case (kind)
      MK_SMALL: begin
        // values within about +-8.0, so the inverse lands in range
        for (int i = 0; i < 9; i++) m[i] = 32'(signed'(m[i]) >>> 12);
      end
      MK_DIAG: begin
        scale = $urandom_range(4, 28);
        for (int i = 0; i < 9; i++) m[i] = 32'(signed'(m[i]) >>> scale);
        m[0] = m[0] + ONE * 4;
        m[4] = m[4] - ONE * 4;
        m[8] = m[8] + ONE * 4;
      end
      MK_SINGULAR: begin
        // repeated row, repeated column or a zero row
        case ($urandom_range(0, 2))
          0: begin m[6] = m[0]; m[7] = m[1]; m[8] = m[2]; end
          1: begin m[1] = m[0]; m[4] = m[3]; m[7] = m[6]; end
          default: begin m[3] = '0; m[4] = '0; m[5] = '0; end
        endcase
      end
      MK_TINY: begin
        // a few LSBs: determinant far below one, inverse saturates
        for (int i = 0; i < 9; i++) m[i] = 32'(signed'(m[i]) >>> $urandom_range(24, 30));
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send(input logic [8:0][31:0] m);
    int gap;
    in_valid <= 1'b1;
    {a22, a21, a20, a12, a11, a10, a02, a01, a00} <= m;
    do @(posedge clk); while (in_stall);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int r;
    @(negedge rst);
    repeat (300) begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 3) == 0);
    end
    out_stall <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else if (r == 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        repeat ($urandom_range(20, 80)) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      end
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("matrix3_inverse_top test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0][31:0] m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero, extremes, signs, tiny and singular cases
    send({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    send('0);
    send({9{32'h7FFF_FFFF}});
    send({9{32'h8000_0000}});
    send({32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
          32'h7FFF_FFFF});
    send({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0,
          32'h8000_0000});
    send({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
          32'h8000_0000});
    send({-ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE * 2});
    send({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    send({-32'sd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    send({9{ONE}});
    send({32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0});
    send({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send({ONE * 3, ONE, 32'd0, ONE, ONE * 3, ONE, 32'd0, ONE, ONE * 3});
    send({32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
          32'h7FFF_FFFF});
    send({32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0,
          32'h0, 32'h0, ONE});

    // sender pause: let the pipeline drain completely
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    m = make_matrix(MK_FULL);
        2, 3, 4: m = make_matrix(MK_SMALL);
        5, 6:    m = make_matrix(MK_DIAG);
        7:       m = make_matrix(MK_SINGULAR);
        default: m = make_matrix(MK_TINY);
      endcase
      send(m);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) $display("matrix3_inverse_top test passed");
    else $display("matrix3_inverse_top test failed");
    $finish;
  end
endmodule
